[rtl/core/w256_pkg.sv]
// Package for the 256-bit arithmetic unit: payload structs, action codes and sequencer states.
// Used by w256_mac and word256_arith_unit_top; no dependencies.
`timescale 1ns / 1ps
package w256_pkg;

	typedef enum logic [2:0] {
		ACT_ADD  = 3'd0,
		ACT_SUB  = 3'd1,
		ACT_MUL  = 3'd2,
		ACT_UDIV = 3'd3,
		ACT_SDIV = 3'd4,
		ACT_UMOD = 3'd5,
		ACT_SMOD = 3'd6,
		ACT_EXP  = 3'd7
	} action_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] a_word0;
		logic [63:0] a_word1;
		logic [63:0] a_word2;
		logic [63:0] a_word3;
		logic [63:0] b_word0;
		logic [63:0] b_word1;
		logic [63:0] b_word2;
		logic [63:0] b_word3;
	} in_item_t;

	typedef struct packed {
		logic [63:0] r_word0;
		logic [63:0] r_word1;
		logic [63:0] r_word2;
		logic [63:0] r_word3;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_EXP_SQ,
		ST_EXP_MUL,
		ST_FIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mac_ctl_t;

endpackage

[rtl/core/w256_mac.sv]
// Sequential multiplier: low W bits of x*y, one 32x32 partial product per cycle.
// Depends on w256_pkg.
`timescale 1ns / 1ps
module w256_mac #(
	parameter int unsigned W = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          x,
	input  logic [W-1:0]          y,
	output w256_pkg::mac_ctl_t    ctl,
	output logic [W-1:0]          p
);
	localparam int unsigned NDig = (W + 31) / 32;
	localparam int unsigned DW = (NDig > 1) ? $clog2(NDig) : 1;
	localparam int unsigned XW = NDig * 32;

	logic [XW-1:0] x_q;
	logic [XW-1:0] y_q;
	logic [XW-1:0] acc_q;
	logic [DW-1:0] i_q;
	logic [DW-1:0] j_q;
	logic          busy_q;
	logic          done_q;
	logic [31:0]   xd;
	logic [31:0]   yd;
	logic [63:0]   prod_s1;
	logic [DW:0]   sh_s1;
	logic          pv_s1;
	logic          last_s1;
	logic [XW+63:0] addend;
	logic          last_pair;

	assign xd = x_q[32*i_q +: 32];
	assign yd = y_q[32*j_q +: 32];
	assign last_pair = ({1'b0, i_q} == (DW+1)'(NDig - 1)) && (j_q == '0);
	assign addend = {{XW{1'b0}}, prod_s1} << (32 * sh_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= pv_s1 && last_s1;
			pv_s1  <= busy_q;
			last_s1 <= busy_q && last_pair;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
			end else if (busy_q) begin
				if (last_pair) begin
					busy_q <= 1'b0;
				end else if ({1'b0, i_q} + {1'b0, j_q} == (DW+1)'(NDig - 1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= XW'(x);
			y_q   <= XW'(y);
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + addend[XW-1:0];
		end
		prod_s1 <= xd * yd;
		sh_s1   <= {1'b0, i_q} + {1'b0, j_q};
	end

	assign p = acc_q[W-1:0];
	assign ctl.start = start;
	assign ctl.busy = busy_q || pv_s1;
	assign ctl.done = done_q;
endmodule

[rtl/core/word256_arith_unit_top.sv]
// Top level of the 256-bit arithmetic unit: sequencer, shared sequential multiplier, output register.
// Depends on w256_pkg and w256_mac.
`timescale 1ns / 1ps
// One item is in flight at a time and in_stall stays high until its result has been
// transferred out. Multiply runs on the shared 32x32 multiplier, one partial product
// per cycle. Divide and remainder run one restoring step per bit on the divide
// subtractor. Exponentiation runs W square rounds and one multiply round per set
// exponent bit, each on the same multiplier.
module word256_arith_unit_top #(
	parameter int unsigned WORD_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  w256_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output w256_pkg::out_item_t  out_data
);
	localparam int unsigned W = 8 * WORD_BYTES;
	localparam int unsigned CW = $clog2(W + 1);

	w256_pkg::state_t state_q;
	w256_pkg::state_t state_d;
	w256_pkg::action_t act_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] q_q;
	logic [W-1:0] r_q;
	logic [W-1:0] acc_q;
	logic [CW-1:0] k_q;
	logic          na_q;
	logic          nb_q;
	logic          out_valid_q;
	logic [W-1:0]  res_q;
	logic [W-1:0]  a_in;
	logic [W-1:0]  b_in;
	logic [255:0]  a_raw;
	logic [255:0]  b_raw;
	logic          take;
	logic          mstart;
	logic [W-1:0]  mx;
	logic [W-1:0]  my;
	logic [W-1:0]  mp;
	w256_pkg::mac_ctl_t mctl;
	logic [W:0]    rsh;
	logic [W:0]    dif;
	logic          signed_div;
	logic [W-1:0]  fix_val;

	assign a_raw = {in_data.a_word3, in_data.a_word2, in_data.a_word1, in_data.a_word0};
	assign b_raw = {in_data.b_word3, in_data.b_word2, in_data.b_word1, in_data.b_word0};
	assign a_in = a_raw[W-1:0];
	assign b_in = b_raw[W-1:0];
	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != w256_pkg::ST_IDLE) || out_valid_q;
	assign signed_div = (act_q == w256_pkg::ACT_SDIV) || (act_q == w256_pkg::ACT_SMOD);

	assign rsh = {r_q, a_q[W-1]};
	assign dif = rsh - {1'b0, b_q};

	w256_mac #(.W(W)) u_mac (
		.clk(clk), .arst_n(arst_n), .start(mstart), .x(mx), .y(my), .ctl(mctl), .p(mp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			w256_pkg::ST_IDLE: begin
				if (take) begin
					state_d = w256_pkg::ST_PREP;
				end
			end
			w256_pkg::ST_PREP: begin
				case (act_q)
					w256_pkg::ACT_ADD, w256_pkg::ACT_SUB: state_d = w256_pkg::ST_DONE;
					w256_pkg::ACT_MUL: state_d = w256_pkg::ST_MUL;
					w256_pkg::ACT_EXP: state_d = w256_pkg::ST_EXP_SQ;
					default: state_d = (b_q == '0) ? w256_pkg::ST_DONE : w256_pkg::ST_DIV;
				endcase
			end
			w256_pkg::ST_DIV: begin
				if (k_q == CW'(1)) begin
					state_d = w256_pkg::ST_FIX;
				end
			end
			w256_pkg::ST_MUL: begin
				if (mctl.done) begin
					state_d = w256_pkg::ST_DONE;
				end
			end
			w256_pkg::ST_EXP_SQ: begin
				if (mctl.done) begin
					if (b_q[W-1]) begin
						state_d = w256_pkg::ST_EXP_MUL;
					end else if (k_q == CW'(1)) begin
						state_d = w256_pkg::ST_DONE;
					end
				end
			end
			w256_pkg::ST_EXP_MUL: begin
				if (mctl.done) begin
					state_d = (k_q == CW'(1)) ? w256_pkg::ST_DONE : w256_pkg::ST_EXP_SQ;
				end
			end
			w256_pkg::ST_FIX: state_d = w256_pkg::ST_DONE;
			w256_pkg::ST_DONE: state_d = w256_pkg::ST_IDLE;
			default: state_d = w256_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mstart = 1'b0;
		mx = acc_q;
		my = acc_q;
		case (state_q)
			w256_pkg::ST_PREP: begin
				mstart = (act_q == w256_pkg::ACT_MUL) || (act_q == w256_pkg::ACT_EXP);
				mx = (act_q == w256_pkg::ACT_MUL) ? a_q : W'(1);
				my = (act_q == w256_pkg::ACT_MUL) ? b_q : W'(1);
			end
			w256_pkg::ST_EXP_SQ: begin
				mstart = mctl.done && (b_q[W-1] || (k_q != CW'(1)));
				mx = mp;
				my = b_q[W-1] ? a_q : mp;
			end
			w256_pkg::ST_EXP_MUL: begin
				mstart = mctl.done && (k_q != CW'(1));
				mx = mp;
				my = mp;
			end
			default: begin
				mstart = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (act_q == w256_pkg::ACT_SDIV) begin
			fix_val = (na_q != nb_q) ? (W'(0) - q_q) : q_q;
		end else if (act_q == w256_pkg::ACT_SMOD) begin
			fix_val = na_q ? (W'(0) - r_q) : r_q;
		end else if (act_q == w256_pkg::ACT_UDIV) begin
			fix_val = q_q;
		end else begin
			fix_val = r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= w256_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == w256_pkg::ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			w256_pkg::ST_IDLE: begin
				if (take) begin
					act_q <= w256_pkg::action_t'(in_data.action);
					a_q   <= a_in;
					b_q   <= b_in;
					na_q  <= a_in[W-1];
					nb_q  <= b_in[W-1];
				end
			end
			w256_pkg::ST_PREP: begin
				k_q <= CW'(W);
				r_q <= '0;
				q_q <= '0;
				res_q <= '0;
				if (act_q == w256_pkg::ACT_ADD) begin
					res_q <= a_q + b_q;
				end else if (act_q == w256_pkg::ACT_SUB) begin
					res_q <= a_q - b_q;
				end else if (signed_div) begin
					if (na_q) a_q <= W'(0) - a_q;
					if (nb_q) b_q <= W'(0) - b_q;
				end
			end
			w256_pkg::ST_DIV: begin
				a_q <= a_q << 1;
				k_q <= k_q - 1'b1;
				if (!dif[W]) begin
					r_q <= dif[W-1:0];
					q_q <= {q_q[W-2:0], 1'b1};
				end else begin
					r_q <= rsh[W-1:0];
					q_q <= {q_q[W-2:0], 1'b0};
				end
			end
			w256_pkg::ST_MUL: begin
				if (mctl.done) res_q <= mp;
			end
			w256_pkg::ST_EXP_SQ: begin
				if (mctl.done) begin
					acc_q <= mp;
					if (!b_q[W-1]) begin
						k_q <= k_q - 1'b1;
						b_q <= b_q << 1;
						res_q <= mp;
					end
				end
			end
			w256_pkg::ST_EXP_MUL: begin
				if (mctl.done) begin
					acc_q <= mp;
					res_q <= mp;
					k_q <= k_q - 1'b1;
					b_q <= b_q << 1;
				end
			end
			w256_pkg::ST_FIX: res_q <= fix_val;
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data.r_word0 = 64'(256'(res_q) >> 0);
	assign out_data.r_word1 = 64'(256'(res_q) >> 64);
	assign out_data.r_word2 = 64'(256'(res_q) >> 128);
	assign out_data.r_word3 = 64'(256'(res_q) >> 192);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(res_q))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.busy |-> !mstart)
		else $error("multiplier restarted while busy");
endmodule

[test/tb.sv]
// Self-checking testbench for word256_arith_unit_top: directed and random items under varied idling.
// A scoreboard class predicts each 256-bit result; depends on w256_pkg and the RTL only.
`timescale 1ns / 1ps
module tb;

	typedef bit [255:0] word_t;

	class arith_scoreboard;
		w256_pkg::out_item_t results_due[$];
		int errors;

		function word_t power(word_t base, word_t expo);
			word_t acc;
			acc = 1;
			for (int k = 255; k >= 0; k--) begin
				acc = acc * acc;
				if (expo[k]) begin
					acc = acc * base;
				end
			end
			return acc;
		endfunction

		function void note_input(w256_pkg::in_item_t it);
			word_t a, b, ua, ub, quo, rem, r;
			w256_pkg::out_item_t o;
			a = {it.a_word3, it.a_word2, it.a_word1, it.a_word0};
			b = {it.b_word3, it.b_word2, it.b_word1, it.b_word0};
			ua = a[255] ? -a : a;
			ub = b[255] ? -b : b;
			quo = (ub == 0) ? word_t'(0) : ua / ub;
			rem = (ub == 0) ? word_t'(0) : ua % ub;
			case (w256_pkg::action_t'(it.action))
				w256_pkg::ACT_ADD: r = a + b;
				w256_pkg::ACT_SUB: r = a - b;
				w256_pkg::ACT_MUL: r = a * b;
				w256_pkg::ACT_UDIV: r = (b == 0) ? word_t'(0) : a / b;
				w256_pkg::ACT_UMOD: r = (b == 0) ? word_t'(0) : a % b;
				w256_pkg::ACT_SDIV: r = (a[255] != b[255]) ? -quo : quo;
				w256_pkg::ACT_SMOD: r = a[255] ? -rem : rem;
				default: r = power(a, b);
			endcase
			o.r_word0 = r[63:0];
			o.r_word1 = r[127:64];
			o.r_word2 = r[191:128];
			o.r_word3 = r[255:192];
			results_due.push_back(o);
		endfunction

		function void check_result(w256_pkg::out_item_t got);
			w256_pkg::out_item_t want;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = results_due.pop_front();
			if (got.r_word0 !== want.r_word0) begin
				$display("%0t: r_word0 expected %h actual %h", $time, want.r_word0, got.r_word0);
				errors++;
			end
			if (got.r_word1 !== want.r_word1) begin
				$display("%0t: r_word1 expected %h actual %h", $time, want.r_word1, got.r_word1);
				errors++;
			end
			if (got.r_word2 !== want.r_word2) begin
				$display("%0t: r_word2 expected %h actual %h", $time, want.r_word2, got.r_word2);
				errors++;
			end
			if (got.r_word3 !== want.r_word3) begin
				$display("%0t: r_word3 expected %h actual %h", $time, want.r_word3, got.r_word3);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	w256_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	w256_pkg::out_item_t out_data;

	arith_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	localparam word_t MinNeg = word_t'(1) << 255;
	localparam word_t AllOnes = '1;

	word256_arith_unit_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_result(out_data);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (quiet_cycles > 200000) begin
			$display("FAIL");
			$finish;
		end
	end

	function word_t rand_word();
		word_t w;
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(7))
			0: w = w >> $urandom_range(255);
			1: w = $urandom_range(3);
			2: w = MinNeg;
			3: w = AllOnes - $urandom_range(2);
			4: w = -(w >> $urandom_range(255));
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_item(w256_pkg::action_t act, word_t a, word_t b);
		w256_pkg::in_item_t it;
		it.action = act;
		{it.a_word3, it.a_word2, it.a_word1, it.a_word0} = a;
		{it.b_word3, it.b_word2, it.b_word1, it.b_word0} = b;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
	endtask

	initial begin
		w256_pkg::action_t act;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(w256_pkg::ACT_ADD, AllOnes, 1);
		send_item(w256_pkg::ACT_ADD, AllOnes, AllOnes);
		send_item(w256_pkg::ACT_SUB, 0, 1);
		send_item(w256_pkg::ACT_SUB, MinNeg, AllOnes);
		send_item(w256_pkg::ACT_MUL, AllOnes, AllOnes);
		send_item(w256_pkg::ACT_MUL, MinNeg, 2);
		send_item(w256_pkg::ACT_UDIV, AllOnes, 0);
		send_item(w256_pkg::ACT_UDIV, AllOnes, 3);
		send_item(w256_pkg::ACT_UMOD, AllOnes, 0);
		send_item(w256_pkg::ACT_UMOD, AllOnes, MinNeg + 7);
		send_item(w256_pkg::ACT_SDIV, MinNeg, AllOnes);
		send_item(w256_pkg::ACT_SDIV, -word_t'(7), 2);
		send_item(w256_pkg::ACT_SDIV, 7, -word_t'(2));
		send_item(w256_pkg::ACT_SDIV, -word_t'(7), 0);
		send_item(w256_pkg::ACT_SMOD, -word_t'(7), 2);
		send_item(w256_pkg::ACT_SMOD, 7, -word_t'(2));
		send_item(w256_pkg::ACT_SMOD, MinNeg, 0);
		send_item(w256_pkg::ACT_EXP, 0, 0);
		send_item(w256_pkg::ACT_EXP, 3, AllOnes);
		send_item(w256_pkg::ACT_EXP, AllOnes, 5);
		send_item(w256_pkg::ACT_EXP, 0, 1);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 36) : 0;
			recv_stall_pct = (ph == 2) ? 64 : ((ph == 3) ? 36 : 0);
			for (int i = 0; i < 210; i++) begin
				if ($urandom_range(99) < 3) begin
					act = w256_pkg::ACT_EXP;
				end else begin
					act = w256_pkg::action_t'($urandom_range(6));
				end
				send_item(act, rand_word(), rand_word());
			end
		end
		in_valid <= 1'b0;

		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
